[design/cbp_pkg.sv]
package cbp_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_COEFFS_DEF = 256;
  localparam int unsigned MAX_WIDTH_DEF  = 16;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Stream word layouts.
  localparam int unsigned COEFF_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_WIDTH = 2'd1;

  // Register reset values.
  localparam logic       DIRECTION_RST = 1'b0;
  localparam logic [4:0] BIT_WIDTH_RST = 5'd8;

  // Mode and housekeeping control handed to the back end.
  typedef struct packed {
    logic unpack;
    logic clear;
  } cbp_ctrl_t;

endpackage

[design/cbp_front.sv]
module cbp_front import cbp_pkg::*; #(
  parameter int unsigned MaxWidth = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IN_TDATA_W-1:0] in_data_i,
  input  logic                  unpack_i,
  input  logic [MaxWidth-1:0]   mask_i,
  input  logic [MaxWidth-1:0]   offset_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [MaxWidth-1:0]   push_data_o
);

  logic signed [COEFF_W-1:0] coeff_s;
  logic [MaxWidth-1:0]       coeff_ext;
  logic [MaxWidth-1:0]       field;
  logic                      val_q;
  logic [MaxWidth-1:0]       data_q;

  assign coeff_s   = in_data_i[COEFF_W-1:0];
  assign coeff_ext = MaxWidth'(coeff_s);

  // Pack mode stores the offset field ready for the stream; unpack mode
  // stores the raw byte in the low bits.
  always_comb begin
    if (unpack_i) begin
      field = MaxWidth'(in_data_i[COEFF_W +: BYTE_W]);
    end else begin
      field = (offset_i - coeff_ext) & mask_i;
    end
  end

  assign in_ready_o   = !val_q || push_ready_i;
  assign push_valid_o = val_q;
  assign push_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
    end else if (in_ready_o) begin
      val_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= field;
    end
  end

endmodule

[design/cbp_fifo.sv]
module cbp_fifo import cbp_pkg::*; #(
  parameter int unsigned Width = MAX_WIDTH_DEF,
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = count_q < CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue occupancy above its depth");

endmodule

[design/cbp_back.sv]
module cbp_back import cbp_pkg::*; #(
  parameter int unsigned MaxWidth  = MAX_WIDTH_DEF,
  parameter int unsigned NumCoeffs = NUM_COEFFS_DEF,
  localparam int unsigned WW = $clog2(MaxWidth + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cbp_ctrl_t              ctrl_i,
  input  logic [WW-1:0]          width_i,
  input  logic [MaxWidth-1:0]    mask_i,
  input  logic [MaxWidth-1:0]    offset_i,
  input  logic                   pop_valid_i,
  output logic                   pop_o,
  input  logic [MaxWidth-1:0]    pop_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_last_o,
  output logic                   out_done_o
);

  localparam int unsigned AccW = MaxWidth + 8;
  localparam int unsigned HW   = $clog2(AccW + 1);
  localparam int unsigned CntW = $clog2(NumCoeffs);
  localparam int unsigned VW   = (MaxWidth > COEFF_W) ? MaxWidth : COEFF_W;

  logic [AccW-1:0] acc_q, acc_d, acc_v, acc_n;
  logic [HW-1:0]   held_q, held_d, held_v, held_n;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            active_q, active_d;
  logic            done_q, done_d;
  logic            done_v, cnt_last;

  logic            have_v, emit, last, pdone, slot_free, step;
  logic [MaxWidth-1:0] field_v;
  logic [VW-1:0]   coeff_wide;
  logic [BYTE_W-1:0]  res_byte;
  logic [COEFF_W-1:0] res_coeff;

  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic [COEFF_W-1:0] out_coeff_q;
  logic               out_last_q, out_done_q;

  assign cnt_last  = cnt_q == CntW'(NumCoeffs - 1);
  assign have_v    = active_q || pop_valid_i;
  assign slot_free = !out_valid_q || out_ready_i;

  // Working view: either the item still being drained or the queue head
  // merged into the accumulator above the bits already held.
  always_comb begin
    if (active_q) begin
      acc_v  = acc_q;
      held_v = held_q;
      done_v = done_q;
    end else begin
      acc_v  = acc_q | (AccW'(pop_data_i) << held_q);
      held_v = ctrl_i.unpack ? held_q + HW'(BYTE_W) : held_q + HW'(width_i);
      done_v = cnt_last;
    end
  end

  assign field_v    = MaxWidth'(acc_v) & mask_i;
  assign coeff_wide = VW'(offset_i) - VW'(field_v);

  always_comb begin
    res_byte  = '0;
    res_coeff = '0;
    if (ctrl_i.unpack) begin
      emit      = held_v >= HW'(width_i);
      held_n    = held_v - HW'(width_i);
      acc_n     = acc_v >> width_i;
      pdone     = cnt_last;
      last      = cnt_last || (held_n < HW'(width_i));
      res_coeff = coeff_wide[COEFF_W-1:0];
    end else begin
      emit      = (held_v >= HW'(8)) || (done_v && held_v != '0);
      held_n    = (held_v >= HW'(8)) ? held_v - HW'(8) : '0;
      acc_n     = acc_v >> 8;
      last      = done_v ? (held_n == '0) : (held_n < HW'(8));
      pdone     = done_v && last;
      res_byte  = acc_v[BYTE_W-1:0];
    end
  end

  // An item that completes nothing is absorbed without the output slot.
  assign step  = have_v && (!emit || slot_free);
  assign pop_o = !active_q && pop_valid_i && step;

  always_comb begin
    acc_d    = acc_q;
    held_d   = held_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = done_q;
    if (ctrl_i.clear) begin
      acc_d    = '0;
      held_d   = '0;
      cnt_d    = '0;
      active_d = 1'b0;
      done_d   = 1'b0;
    end else if (step) begin
      if (pop_o && !ctrl_i.unpack) begin
        cnt_d  = done_v ? '0 : cnt_q + 1'b1;
        done_d = done_v;
      end
      if (emit) begin
        acc_d    = pdone ? '0 : acc_n;
        held_d   = pdone ? '0 : held_n;
        active_d = !last;
        if (ctrl_i.unpack) begin
          cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
        end
      end else begin
        acc_d    = acc_v;
        held_d   = held_v;
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      held_q   <= held_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
      done_q   <= done_d;
      if (step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_byte_q  <= res_byte;
      out_coeff_q <= res_coeff;
      out_last_q  <= last;
      out_done_q  <= pdone;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_coeff_q, out_byte_q};
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

  a_pack_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && !ctrl_i.unpack |-> (held_q >= HW'(8)) || done_q)
    else $error("pack drain active without a full byte or a pending end");

  a_unpack_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q && ctrl_i.unpack |-> held_q < HW'(width_i))
    else $error("unpack left a whole field in the accumulator");

  a_poly_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit && pdone && !ctrl_i.clear |=>
      held_q == '0 && cnt_q == '0 && !active_q)
    else $error("stream state not cleared after the polynomial ended");

endmodule

[design/coeff_bit_pack_unpack.sv]
// An accepted input word passes the front register and the queue before its first result
// word is registered in the back end; its further result words follow one per cycle while
// the receiver keeps up. Throughput: one input word per cycle while each yields at most one
// result word and no stall; else one result word per cycle, bounded by the result register.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and the queue, clears the
// accumulator and counters, and sets direction to pack and bit_width to 8.
module coeff_bit_pack_unpack import cbp_pkg::*; #(
  parameter int unsigned NumCoeffs = NUM_COEFFS_DEF,
  parameter int unsigned MaxWidth  = MAX_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] in_coeff, [23:16] in_byte
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [23:8] out_coeff
  output logic                   m_axis_tlast,   // run_last
  output logic                   m_axis_tuser    // poly_done
);

  localparam int unsigned WW = $clog2(MaxWidth + 1);

  logic                direction_q;
  logic [4:0]          bit_width_q;
  logic [WW-1:0]       width_eff;
  logic [MaxWidth-1:0] mask, offset;
  logic                cfg_write, cfg_hit;
  cbp_ctrl_t           ctrl;

  logic                push_valid, push_ready, pop_valid, pop;
  logic [MaxWidth-1:0] push_data, pop_data;

  // The configuration port never stalls. Writes are expected only while the
  // block is idle; any write to a known register starts a fresh polynomial.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    case (cfg_index_i)
      REG_DIRECTION: cfg_hit = cfg_write;
      REG_BIT_WIDTH: cfg_hit = cfg_write;
      default:       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIRECTION_RST;
      bit_width_q <= BIT_WIDTH_RST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        REG_DIRECTION: direction_q <= cfg_data_i[0];
        REG_BIT_WIDTH: bit_width_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // A width of zero behaves as one, and anything above the supported
  // maximum is held at the maximum.
  always_comb begin
    if (bit_width_q == '0) begin
      width_eff = WW'(1);
    end else if (bit_width_q > 5'(MaxWidth)) begin
      width_eff = WW'(MaxWidth);
    end else begin
      width_eff = WW'(bit_width_q);
    end
  end

  // Field mask of width_eff ones; the coefficient offset is half of it.
  assign mask   = ~({MaxWidth{1'b1}} << width_eff);
  assign offset = mask >> 1;

  assign ctrl.unpack = direction_q;
  assign ctrl.clear  = cfg_hit;

  // Front end: takes input words and turns each into a stream field (pack)
  // or a raw byte (unpack), ahead of the queue.
  cbp_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .unpack_i     (direction_q),
    .mask_i       (mask),
    .offset_i     (offset),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Short queue so the front keeps accepting while the back drains an item
  // that produces several result words.
  cbp_fifo #(
    .Width (MaxWidth),
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  // Back end: owns the bit accumulator and the coefficient count, and emits
  // one byte or one coefficient per cycle into the result register while it is free.
  cbp_back #(
    .MaxWidth  (MaxWidth),
    .NumCoeffs (NumCoeffs)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .width_i     (width_eff),
    .mask_i      (mask),
    .offset_i    (offset),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

  // The word that ends a polynomial is always the last one of its input word.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("polynomial end flagged on a word that is not the last");

endmodule

[tb/tb_coeff_bit_pack_unpack.sv]
`timescale 1ns / 1ps

module tb_coeff_bit_pack_unpack;
  import cbp_pkg::*;

  // Random words after the directed table. The long pack phase alone takes a whole
  // polynomial, so the run is a little longer than a plain stream would need.
  localparam int unsigned RANDOM_WORDS = 340;
  // Slowest correct run: some 400 words, at most eight result words each, behind a
  // receiver that stalls more than half the time. The limit is many times that.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // The first result is registered behind the front register and the queue, which holds two
  // more, so SETTLE_CYCLES covers a word that is still in flight with no result.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned MAX_REPORTS   = 60;

  // Register indexes past the end of the register list: writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_HI = 2'd3;
  localparam logic [CFG_DATA_W-1:0] DIR_PACK     = 5'd0;
  localparam logic [CFG_DATA_W-1:0] DIR_UNPACK   = 5'd1;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  // One result word as it travels on the result stream.
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [COEFF_W-1:0] out_coeff;
    logic               run_last;
    logic               poly_done;
  } result_word_t;

  // One row of the directed table: either a register write or an input word. A word row
  // may carry a typed result, which then stands for the single result word it causes.
  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
    logic [IN_TDATA_W-1:0] word;
    bit                    typed;
    result_word_t          want;
  } stim_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] in_coeff, [23:16] in_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] out_byte, [23:8] out_coeff
  logic                   m_axis_tlast;         // run_last
  logic                   m_axis_tuser;         // poly_done

  coeff_bit_pack_unpack uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the registers as the block should hold them, and the bitstream
  // gearbox with its pending bits (lowest first), their count and the coefficient count.
  logic         cfg_unpack;
  logic [4:0]   cfg_width;
  logic [31:0]  gear_bits;
  int unsigned  gear_held;
  int unsigned  coeff_count;

  result_word_t predicted[$];        // result words of the word just accepted
  result_word_t expected_results[$]; // result words still owed by the block
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  // A width of zero behaves as one bit, and anything wider than the block's maximum is
  // clamped to that maximum.
  function automatic int unsigned clamp_width(logic [4:0] raw);
    int unsigned w;
    w = 32'(raw);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic void clear_gearbox();
    gear_bits   = '0;
    gear_held   = 0;
    coeff_count = 0;
  endfunction

  // Every write to a real register starts a new polynomial; writes to the spare indexes
  // change nothing at all, the gearbox included.
  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DIRECTION: begin
        cfg_unpack = val[0];
        clear_gearbox();
      end
      REG_BIT_WIDTH: begin
        cfg_width = val;
        clear_gearbox();
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the result words that one accepted input word causes, into predicted.
  function automatic void predict_word(logic [IN_TDATA_W-1:0] word);
    int unsigned  w;
    logic [31:0]  offset;
    logic [31:0]  mask;
    logic [31:0]  coeff;
    logic [31:0]  field;
    bit           done;
    result_word_t r;
    w      = clamp_width(cfg_width);
    offset = (32'd1 << (w - 1)) - 32'd1;
    mask   = (32'd1 << w) - 32'd1;
    predicted.delete();
    if (!cfg_unpack) begin
      // Pack: the offset coefficient, reduced to w bits, goes in above the held bits and
      // every whole byte leaves from the bottom.
      coeff       = {{16{word[15]}}, word[15:0]};
      field       = (offset - coeff) & mask;
      gear_bits   = gear_bits | (field << gear_held);
      gear_held   = gear_held + w;
      coeff_count = coeff_count + 1;
      done        = (coeff_count >= NUM_COEFFS_DEF);
      while (gear_held >= 8) begin
        r = '{out_byte: gear_bits[7:0], out_coeff: '0, run_last: 1'b0, poly_done: 1'b0};
        predicted.push_back(r);
        gear_bits = gear_bits >> 8;
        gear_held = gear_held - 8;
      end
      if (done) begin
        // Any leftover bits go out zero-padded in one last byte.
        if (gear_held > 0) begin
          r = '{out_byte: gear_bits[7:0], out_coeff: '0, run_last: 1'b0, poly_done: 1'b0};
          predicted.push_back(r);
        end
        if (predicted.size() > 0) begin
          r = predicted.pop_back();
          r.poly_done = 1'b1;
          predicted.push_back(r);
        end
        clear_gearbox();
      end
    end else begin
      // Unpack: the byte goes in above the held bits and every whole field leaves, at most
      // eight of them; bits left over when the polynomial completes are dropped.
      gear_bits = gear_bits | ({24'd0, word[23:16]} << gear_held);
      gear_held = gear_held + 8;
      while (gear_held >= w && predicted.size() < 8) begin
        field       = gear_bits & mask;
        gear_bits   = gear_bits >> w;
        gear_held   = gear_held - w;
        coeff_count = coeff_count + 1;
        done        = (coeff_count >= NUM_COEFFS_DEF);
        coeff       = offset - field;
        r = '{out_byte: '0, out_coeff: coeff[15:0], run_last: 1'b0, poly_done: done};
        predicted.push_back(r);
        if (done) begin
          clear_gearbox();
          break;
        end
      end
    end
    if (predicted.size() > 0) begin
      r = predicted.pop_back();
      r.run_last = 1'b1;
      predicted.push_back(r);
    end
  endfunction

  function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
    if (error_count < MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    error_count = error_count + 1;
  endfunction

  function automatic void set_idle(int unsigned sender_pct, int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row       = '{kind: ROW_CFG, index: idx, value: val, word: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t word_row(logic [7:0] in_byte, logic [15:0] in_coeff,
                                         bit typed = 1'b0, logic [7:0] want_byte = '0,
                                         logic [15:0] want_coeff = '0);
    stim_row_t row;
    row = '{kind: ROW_WORD, index: '0, value: '0, word: {in_byte, in_coeff}, typed: typed,
            want: '{out_byte: want_byte, out_coeff: want_coeff, run_last: 1'b1,
                    poly_done: 1'b0}};
    return row;
  endfunction

  // Offers one word on the input stream, idling first at random, and books the result
  // words it owes once it has been taken.
  task automatic send_word(logic [IN_TDATA_W-1:0] word, bit typed, result_word_t want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(word);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      foreach (predicted[i]) expected_results.push_back(predicted[i]);
    end
  endtask

  // Takes the input stream down and waits until every owed result word has come, then
  // waits settle more cycles for a word that may still be in flight without a result.
  task automatic drain_results(int unsigned settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Register writes happen only once the block has gone quiet.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain_results(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_config(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver decides afresh at every falling edge whether it takes a word.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Each result word taken is held against the oldest one still owed, field by field.
  always @(posedge clk_i) begin : check_results
    result_word_t got;
    result_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_byte  = m_axis_tdata[BYTE_W-1:0];
      got.out_coeff = m_axis_tdata[BYTE_W +: COEFF_W];
      got.run_last  = m_axis_tlast;
      got.poly_done = m_axis_tuser;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", 0, 32'(got));
      end else begin
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch("out_byte", 32'(want.out_byte), 32'(got.out_byte));
        if (got.out_coeff !== want.out_coeff)
          report_mismatch("out_coeff", 32'(want.out_coeff), 32'(got.out_coeff));
        if (got.run_last !== want.run_last)
          report_mismatch("run_last", 32'(want.run_last), 32'(got.run_last));
        if (got.poly_done !== want.poly_done)
          report_mismatch("poly_done", 32'(want.poly_done), 32'(got.poly_done));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words still owed", $time,
               expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t                directed[$];
    int unsigned              random_words;
    int unsigned              phase;
    int unsigned              len;
    int unsigned              eff_w;
    logic                     unpack;
    logic [CFG_DATA_W-1:0]    width_val;
    logic [CFG_DATA_W-1:0]    dir_val;
    logic [7:0]               in_byte;
    logic [15:0]              in_coeff;

    cfg_unpack = DIRECTION_RST;
    cfg_width  = BIT_WIDTH_RST;
    clear_gearbox();
    set_idle(17, 56);

    // After reset the block packs eight-bit fields, so the first few bytes can be read
    // straight off: the field is 127 minus the coefficient.
    directed.push_back(word_row(8'h00, 16'h007f, 1'b1, 8'h00, 16'h0000));
    directed.push_back(word_row(8'h00, 16'hff80, 1'b1, 8'hff, 16'h0000));
    directed.push_back(word_row(8'h00, 16'h0000, 1'b1, 8'h7f, 16'h0000));
    // Coefficients far outside eight bits wrap.
    directed.push_back(word_row(8'hff, 16'h7fff));
    directed.push_back(word_row(8'h00, 16'h8000));
    // A width above the maximum behaves as the maximum.
    directed.push_back(cfg_row(REG_BIT_WIDTH, 5'd31));
    directed.push_back(word_row(8'h00, 16'h8000));
    directed.push_back(word_row(8'h00, 16'h7fff));
    // Three-bit fields: the first word leaves bits held and yields nothing, and writes to
    // the spare indexes must not throw those bits away.
    directed.push_back(cfg_row(REG_BIT_WIDTH, 5'd3));
    directed.push_back(word_row(8'h00, 16'h0005));
    directed.push_back(cfg_row(REG_SPARE_LO, 5'd31));
    directed.push_back(cfg_row(REG_SPARE_HI, 5'd0));
    directed.push_back(word_row(8'h00, 16'h0001));
    directed.push_back(word_row(8'h00, 16'h0002));
    // Unpack with a width of zero, which behaves as one bit: eight coefficients a byte.
    directed.push_back(cfg_row(REG_DIRECTION, DIR_UNPACK));
    directed.push_back(cfg_row(REG_BIT_WIDTH, 5'd0));
    directed.push_back(word_row(8'hff, 16'h0000));
    directed.push_back(word_row(8'h00, 16'hffff));
    // Sixteen-bit fields span two bytes; the extremes give minus one and zero.
    directed.push_back(cfg_row(REG_BIT_WIDTH, 5'd16));
    directed.push_back(word_row(8'h00, 16'h0000));
    directed.push_back(word_row(8'h80, 16'h0000, 1'b1, 8'h00, 16'hffff));
    directed.push_back(word_row(8'hff, 16'h0000));
    directed.push_back(word_row(8'h7f, 16'h0000, 1'b1, 8'h00, 16'h0000));
    // A half-built field is dropped by a register write, even one that keeps the mode;
    // only bit zero of the data selects the direction.
    directed.push_back(cfg_row(REG_BIT_WIDTH, 5'd17));
    directed.push_back(word_row(8'h12, 16'h0000));
    directed.push_back(cfg_row(REG_DIRECTION, 5'b00011));
    directed.push_back(word_row(8'h34, 16'h0000));
    directed.push_back(word_row(8'h56, 16'h0000));
    // Back to packing, with an odd width that straddles bytes.
    directed.push_back(cfg_row(REG_DIRECTION, DIR_PACK));
    directed.push_back(cfg_row(REG_BIT_WIDTH, 5'd13));
    directed.push_back(word_row(8'h00, 16'h1234));
    directed.push_back(word_row(8'h00, 16'hedcb));
    directed.push_back(word_row(8'h00, 16'h0fff));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_reg(directed[i].index, directed[i].value);
      else
        send_word(directed[i].word, directed[i].typed, directed[i].want);
    end

    // Random phases, each under a fresh configuration. The first few are fixed in kind so
    // that whole polynomials complete in both directions and the extreme widths are run.
    random_words = 0;
    phase        = 0;
    while (random_words < RANDOM_WORDS) begin
      case (phase)
        0: begin
          unpack    = 1'b1;
          width_val = 5'($urandom_range(0, 1));
        end
        1: begin
          unpack    = 1'b0;
          width_val = 5'($urandom_range(16, 31));
        end
        2: begin
          unpack    = 1'b0;
          width_val = 5'($urandom_range(1, 16));
        end
        3: begin
          unpack    = 1'b1;
          width_val = 5'd2;
        end
        default: begin
          unpack = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 3) != 0)
            width_val = 5'($urandom_range(1, 16));
          else
            width_val = 5'($urandom_range(0, 31));
        end
      endcase
      dir_val = {4'($urandom_range(0, 15)), unpack};
      eff_w   = clamp_width(width_val);

      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_DIRECTION, dir_val);
        write_reg(REG_BIT_WIDTH, width_val);
      end else begin
        write_reg(REG_BIT_WIDTH, width_val);
        write_reg(REG_DIRECTION, dir_val);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  5'($urandom_range(0, 31)));

      // Narrow unpack phases and one long pack phase reach the end of a polynomial.
      if (!unpack)
        len = (phase == 2) ? NUM_COEFFS_DEF + $urandom_range(0, 20) : $urandom_range(6, 40);
      else if (eff_w <= 2)
        len = NUM_COEFFS_DEF * eff_w / 8 + $urandom_range(0, 24);
      else
        len = $urandom_range(6, 40);
      // Phases after the long pack phase stop at the word budget.
      if (phase > 2 && len > RANDOM_WORDS - random_words)
        len = RANDOM_WORDS - random_words;

      repeat (len) begin
        if (random_words >= 2 * RANDOM_WORDS / 3)
          set_idle(0, 0);
        else if (random_words >= RANDOM_WORDS / 3)
          set_idle(56, 17);
        else
          set_idle(17, 56);
        in_byte = 8'($urandom_range(0, 255));
        // Mostly coefficients that fit the field, the rest anywhere in sixteen bits.
        if ($urandom_range(0, 3) != 0)
          in_coeff = 16'(int'($urandom_range(0, (1 << eff_w) - 1)) -
                         int'((1 << (eff_w - 1)) - 1));
        else
          in_coeff = 16'($urandom_range(0, 65535));
        send_word({in_byte, in_coeff}, 1'b0, '0);
        random_words = random_words + 1;
        // Now and then the sender holds off until the block has caught up completely.
        if (random_words == 100 || $urandom_range(0, 59) == 0)
          drain_results(0);
      end
      phase = phase + 1;
    end

    drain_results(SETTLE_CYCLES);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
design/cbp_pkg.sv
design/cbp_front.sv
design/cbp_fifo.sv
design/cbp_back.sv
design/coeff_bit_pack_unpack.sv
tb/tb_coeff_bit_pack_unpack.sv
